// ----- rtl/tms_pkg.sv -----
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and constants for the triangle midpoint subdivider.
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int unsigned IdxW         = 24;
  localparam int unsigned PosW         = 32;
  localparam int unsigned EdgeCapacity = 4096;
  localparam int unsigned IndexBits    = 24;

  localparam logic KindVertex = 1'b0;
  localparam logic KindFace   = 1'b1;

  typedef struct packed {
    logic [IdxW-1:0]        corner_a;
    logic [IdxW-1:0]        corner_b;
    logic [IdxW-1:0]        corner_c;
    logic signed [PosW-1:0] a_x;
    logic signed [PosW-1:0] a_y;
    logic signed [PosW-1:0] a_z;
    logic signed [PosW-1:0] b_x;
    logic signed [PosW-1:0] b_y;
    logic signed [PosW-1:0] b_z;
    logic signed [PosW-1:0] c_x;
    logic signed [PosW-1:0] c_y;
    logic signed [PosW-1:0] c_z;
  } in_t;

  typedef struct packed {
    logic                   item_kind;
    logic [IdxW-1:0]        new_index;
    logic signed [PosW-1:0] mid_x;
    logic signed [PosW-1:0] mid_y;
    logic signed [PosW-1:0] mid_z;
    logic [IdxW-1:0]        face_first;
    logic [IdxW-1:0]        face_second;
    logic [IdxW-1:0]        face_third;
    logic [IdxW-1:0]        edge_low;
    logic [IdxW-1:0]        edge_high;
    logic                   table_full;
    logic                   last;
  } out_t;

endpackage

// ----- rtl/tms_ram.sv -----
// ----------------------------------------------------------------------------
// tms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/triangle_midpoint_subdivider_top.sv -----
// ----------------------------------------------------------------------------
// triangle_midpoint_subdivider_top
// Splits each triangle into four, assigning midpoint vertices per edge through
// an open-addressed edge hash table held in one RAM of twice the capacity,
// rounded up to a power of two. Each edge passes hash, read and compare steps,
// repeats read and compare per extra probe and takes a vertex step when it
// emits a vertex word; four face words then close the triangle. A word is
// taken only when idle; vertex and face words wait under output stalls.
// Reset and every base count write start a clearing pass over all table
// entries (8192 by default); no word is taken then.
// ----------------------------------------------------------------------------
module triangle_midpoint_subdivider_top #(
  parameter int unsigned EDGE_CAPACITY = tms_pkg::EdgeCapacity,
  parameter int unsigned INDEX_BITS    = tms_pkg::IndexBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  tms_pkg::in_t           in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tms_pkg::out_t          out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [tms_pkg::IdxW-1:0] cfg_data_i
);

  localparam int unsigned ABits  = $clog2(EDGE_CAPACITY) + 1;
  localparam int unsigned Depth  = 2 ** ABits;
  localparam int unsigned KeyW   = 2 * INDEX_BITS;
  localparam int unsigned EntW   = 1 + KeyW + INDEX_BITS;
  localparam int unsigned CntW   = $clog2(EDGE_CAPACITY) + 1;

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StHash  = 7'b0000100,
    StRead  = 7'b0001000,
    StCheck = 7'b0010000,
    StVert  = 7'b0100000,
    StFace  = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  tms_pkg::in_t          item_q, item_d;
  logic [INDEX_BITS-1:0] v_q [3];
  logic [INDEX_BITS-1:0] v_d [3];
  logic [INDEX_BITS-1:0] m_q [3];
  logic [INDEX_BITS-1:0] m_d [3];
  logic [1:0]            j_q, j_d, f_q, f_d;
  logic [ABits-1:0]      addr_q, addr_d;
  logic [INDEX_BITS-1:0] nv_q, nv_d;
  logic [CntW-1:0]       used_q, used_d;
  logic                  full_q, full_d;
  tms_pkg::out_t         out_q, out_d;
  logic                  ov_q, ov_d;

  logic                  we, re;
  logic [ABits-1:0]      waddr;
  logic [EntW-1:0]       wdata, rdata;
  logic [1:0]            k;
  logic [INDEX_BITS-1:0] lo, hi;
  logic [KeyW-1:0]       key;
  logic                  slot_free;
  logic                  hit_valid;
  logic [KeyW-1:0]       hit_key;
  logic [INDEX_BITS-1:0] hit_vert;
  logic signed [tms_pkg::PosW:0] sx, sy, sz;
  logic signed [tms_pkg::PosW-1:0] px, py, pz, qx, qy, qz;

  function automatic logic [ABits-1:0] hash_key(input logic [KeyW-1:0] kv);
    logic [ABits-1:0] h;
    h = '0;
    for (int i = 0; i < KeyW; i++) begin
      h[i % ABits] = h[i % ABits] ^ kv[i];
    end
    return h;
  endfunction

  tms_ram #(
    .Width(EntW),
    .Depth(Depth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  assign k         = (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
  assign lo        = (v_q[j_q] < v_q[k]) ? v_q[j_q] : v_q[k];
  assign hi        = (v_q[j_q] < v_q[k]) ? v_q[k] : v_q[j_q];
  assign key       = {lo, hi};
  assign hit_valid = rdata[EntW-1];
  assign hit_key   = rdata[EntW-2 -: KeyW];
  assign hit_vert  = rdata[INDEX_BITS-1:0];
  assign slot_free = !ov_q || out_ready_i;
  assign re        = (state_q == StRead);

  always_comb begin
    unique case (j_q)
      2'd0: begin
        px = item_q.a_x; py = item_q.a_y; pz = item_q.a_z;
        qx = item_q.b_x; qy = item_q.b_y; qz = item_q.b_z;
      end
      2'd1: begin
        px = item_q.b_x; py = item_q.b_y; pz = item_q.b_z;
        qx = item_q.c_x; qy = item_q.c_y; qz = item_q.c_z;
      end
      default: begin
        px = item_q.c_x; py = item_q.c_y; pz = item_q.c_z;
        qx = item_q.a_x; qy = item_q.a_y; qz = item_q.a_z;
      end
    endcase
    sx = (tms_pkg::PosW+1)'(px) + (tms_pkg::PosW+1)'(qx);
    sy = (tms_pkg::PosW+1)'(py) + (tms_pkg::PosW+1)'(qy);
    sz = (tms_pkg::PosW+1)'(pz) + (tms_pkg::PosW+1)'(qz);
  end

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    v_d     = v_q;
    m_d     = m_q;
    j_d     = j_q;
    f_d     = f_q;
    addr_d  = addr_q;
    nv_d    = nv_q;
    used_d  = used_q;
    full_d  = full_q;
    out_d   = out_q;
    ov_d    = ov_q && !out_ready_i;
    we      = 1'b0;
    waddr   = addr_q;
    wdata   = {1'b1, key, nv_q};

    unique case (state_q)
      StClear: begin
        we    = 1'b1;
        wdata = '0;
        addr_d = addr_q + 1'b1;
        if (&addr_q) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          v_d[0]  = INDEX_BITS'(in_data_i.corner_a);
          v_d[1]  = INDEX_BITS'(in_data_i.corner_b);
          v_d[2]  = INDEX_BITS'(in_data_i.corner_c);
          j_d     = 2'd0;
          state_d = StHash;
        end
      end
      StHash: begin
        addr_d  = hash_key(key);
        state_d = StRead;
      end
      StRead: begin
        state_d = StCheck;
      end
      StCheck: begin
        if (hit_valid && hit_key == key) begin
          m_d[j_q] = hit_vert;
          if (j_q == 2'd2) begin
            f_d     = 2'd0;
            state_d = StFace;
          end else begin
            j_d     = j_q + 2'd1;
            state_d = StHash;
          end
        end else if (hit_valid) begin
          addr_d  = addr_q + 1'b1;
          state_d = StRead;
        end else begin
          m_d[j_q] = nv_q;
          nv_d     = nv_q + 1'b1;
          full_d   = (used_q >= CntW'(EDGE_CAPACITY));
          if (!full_d) begin
            we     = 1'b1;
            used_d = used_q + 1'b1;
          end
          state_d = StVert;
        end
      end
      StVert: begin
        if (slot_free) begin
          out_d             = '0;
          out_d.item_kind   = tms_pkg::KindVertex;
          out_d.new_index   = tms_pkg::IdxW'(m_q[j_q]);
          out_d.mid_x       = sx[tms_pkg::PosW:1];
          out_d.mid_y       = sy[tms_pkg::PosW:1];
          out_d.mid_z       = sz[tms_pkg::PosW:1];
          out_d.edge_low    = tms_pkg::IdxW'(lo);
          out_d.edge_high   = tms_pkg::IdxW'(hi);
          out_d.table_full  = full_q;
          ov_d              = 1'b1;
          if (j_q == 2'd2) begin
            f_d     = 2'd0;
            state_d = StFace;
          end else begin
            j_d     = j_q + 2'd1;
            state_d = StHash;
          end
        end
      end
      StFace: begin
        if (slot_free) begin
          out_d           = '0;
          out_d.item_kind = tms_pkg::KindFace;
          unique case (f_q)
            2'd0: begin
              out_d.face_first  = tms_pkg::IdxW'(m_q[0]);
              out_d.face_second = tms_pkg::IdxW'(m_q[1]);
              out_d.face_third  = tms_pkg::IdxW'(m_q[2]);
            end
            2'd1: begin
              out_d.face_first  = tms_pkg::IdxW'(v_q[0]);
              out_d.face_second = tms_pkg::IdxW'(m_q[0]);
              out_d.face_third  = tms_pkg::IdxW'(m_q[2]);
            end
            2'd2: begin
              out_d.face_first  = tms_pkg::IdxW'(v_q[1]);
              out_d.face_second = tms_pkg::IdxW'(m_q[1]);
              out_d.face_third  = tms_pkg::IdxW'(m_q[0]);
            end
            default: begin
              out_d.face_first  = tms_pkg::IdxW'(v_q[2]);
              out_d.face_second = tms_pkg::IdxW'(m_q[2]);
              out_d.face_third  = tms_pkg::IdxW'(m_q[1]);
            end
          endcase
          out_d.last = (f_q == 2'd3);
          ov_d       = 1'b1;
          f_d        = f_q + 2'd1;
          if (f_q == 2'd3) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_valid_i) begin
      nv_d    = INDEX_BITS'(cfg_data_i);
      used_d  = '0;
      addr_d  = '0;
      state_d = StClear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      j_q     <= '0;
      f_q     <= '0;
      addr_q  <= '0;
      nv_q    <= '0;
      used_q  <= '0;
      full_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      f_q     <= f_d;
      addr_q  <= addr_d;
      nv_q    <= nv_d;
      used_q  <= used_d;
      full_q  <= full_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    v_q    <= v_d;
    m_q    <= m_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(EDGE_CAPACITY))
    else $error("edge table count exceeds capacity");

  a_face_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_q.item_kind == tms_pkg::KindFace |-> !out_q.table_full)
    else $error("table full flag on a face word");

  a_last_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_q.last |-> out_q.item_kind == tms_pkg::KindFace)
    else $error("last flag on a vertex word");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == StHash)
    else $error("accepted word did not start a lookup");

endmodule
